// ----- rtl/gnode_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnode_pkg
// Shared types and constants for the gravity node interaction block.
// ----------------------------------------------------------------------------
package gnode_pkg;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_THETA = 2'd0;
    localparam logic [1:0] REG_GRAV  = 2'd1;
    localparam logic [1:0] REG_SOFT  = 2'd2;

    localparam logic [15:0] THETA_RESET = 16'd2048;
    localparam logic [23:0] GRAV_RESET  = 24'd1119711;
    localparam logic [31:0] SOFT_RESET  = 32'd1638400;

    // result decision codes
    localparam logic [1:0] DEC_EMPTY = 2'd0;
    localparam logic [1:0] DEC_FORCE = 2'd1;
    localparam logic [1:0] DEC_OPEN  = 2'd2;
    localparam logic [1:0] DEC_SELF  = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int CNT_W       = 2;
    localparam int DIV_STEPS   = 48;

    typedef enum logic [1:0] {
        CLS_EMPTY,
        CLS_SELF,
        CLS_LEAF,
        CLS_INNER
    } node_class_t;

    typedef struct packed {
        logic        first;
        logic        last;
        node_class_t cls;
        logic        sign_x;
        logic        sign_y;
        logic [26:0] abs_x;
        logic [26:0] abs_y;
        logic [31:0] pmass;
        logic [31:0] nmass;
        logic [26:0] width;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_SQRT,
        ST_MUL2,
        ST_DENACC,
        ST_DIVGO,
        ST_DIV,
        ST_ACC,
        ST_RESULT
    } back_state_t;

endpackage

// ----- rtl/gnode_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnode_front
// Accepts items, classifies the node and forms distances, queues jobs.
// ----------------------------------------------------------------------------
module gnode_front
    import gnode_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               first,
    input  logic signed [26:0] particle_x,
    input  logic signed [26:0] particle_y,
    input  logic [31:0]        particle_mass,
    input  logic [13:0]        particle_id,
    input  logic signed [26:0] node_cm_x,
    input  logic signed [26:0] node_cm_y,
    input  logic [31:0]        node_mass,
    input  logic [26:0]        node_width,
    input  logic               node_is_leaf,
    input  logic [13:0]        node_particle,
    input  logic               last,
    output logic               job_valid,
    input  logic               job_take,
    output job_t               job
);

    job_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_ok;
    logic [27:0]      dx;
    logic [27:0]      dy;
    logic [27:0]      neg_dx;
    logic [27:0]      neg_dy;
    job_t             new_job;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign push_ok   = push && !full;
    assign job       = q_mem[rd_ptr_reg];

    assign dx     = {node_cm_x[26], node_cm_x} - {particle_x[26], particle_x};
    assign dy     = {node_cm_y[26], node_cm_y} - {particle_y[26], particle_y};
    assign neg_dx = -dx;
    assign neg_dy = -dy;

    always_comb
    begin
        new_job.first  = first;
        new_job.last   = last;
        new_job.sign_x = dx[27];
        new_job.sign_y = dy[27];
        new_job.abs_x  = dx[27] ? neg_dx[26:0] : dx[26:0];
        new_job.abs_y  = dy[27] ? neg_dy[26:0] : dy[26:0];
        new_job.pmass  = particle_mass;
        new_job.nmass  = node_mass;
        new_job.width  = node_width;
        if (node_mass == '0)
        begin
            new_job.cls = CLS_EMPTY;
        end
        else if (node_is_leaf && (node_particle == particle_id))
        begin
            new_job.cls = CLS_SELF;
        end
        else if (node_is_leaf)
        begin
            new_job.cls = CLS_LEAF;
        end
        else
        begin
            new_job.cls = CLS_INNER;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !job_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && job_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (job_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ----- rtl/gnode_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnode_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gnode_sqrt
    import gnode_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] radicand,
    output logic        done,
    output logic [27:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [55:0] v_reg;
    logic [55:0] res_reg;
    logic [55:0] bit_reg;
    logic [56:0] trial;
    logic        ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = ({1'b0, v_reg} >= trial);
    assign done  = done_reg;
    assign root  = res_reg[27:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, 54'b0};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial[55:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// ----- rtl/gnode_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnode_div
// Restoring divider for one force axis, 48 quotient bits plus overflow flag.
// ----------------------------------------------------------------------------
module gnode_div
    import gnode_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [122:0] num,
    input  logic [83:0]  den,
    output logic         done,
    output logic         ovf,
    output logic [47:0]  quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [83:0] rem_reg;
    logic [47:0] low_reg;
    logic [47:0] quot_reg;
    logic        ovf_reg;
    logic [84:0] trial;
    logic [84:0] diff;
    logic        ge;

    assign trial = {rem_reg, low_reg[47]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});
    assign done  = done_reg;
    assign ovf   = ovf_reg;
    assign quot  = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient of 2^48 or more is flagged up front and clamped later
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {9'b0, num[122:48]};
            low_reg  <= num[47:0];
            ovf_reg  <= ({9'b0, num[122:48]} >= den);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[83:0] : trial[83:0];
            low_reg  <= {low_reg[46:0], 1'b0};
            quot_reg <= {quot_reg[46:0], ge};
        end
    end

endmodule

// ----- rtl/gnode_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnode_back
// Sequencer with shared 32x32 multiplier, sqrt and divide units, force sums
// and the result register.
// ----------------------------------------------------------------------------
module gnode_back
    import gnode_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_take,
    input  logic [15:0]        theta,
    input  logic [23:0]        grav_constant,
    input  logic [31:0]        softening_sq,
    input  logic               pop,
    output logic               empty,
    output logic [1:0]         decision,
    output logic signed [47:0] force_x,
    output logic signed [47:0] force_y,
    output logic               done_res
);

    localparam logic [4:0] STEP_AX     = 5'd0;
    localparam logic [4:0] STEP_AY     = 5'd1;
    localparam logic [4:0] STEP_THETA  = 5'd2;
    localparam logic [4:0] STEP_WIDTH  = 5'd3;
    localparam logic [4:0] STEP_GM     = 5'd4;
    localparam logic [4:0] STEP_NAX    = 5'd5;
    localparam logic [4:0] STEP_NAY    = 5'd6;
    localparam logic [4:0] STEP_RHS_LO = 5'd7;
    localparam logic [4:0] STEP_RHS_HI = 5'd8;
    localparam logic [4:0] STEP_NX_LL  = 5'd9;
    localparam logic [4:0] STEP_NX_LH  = 5'd10;
    localparam logic [4:0] STEP_NX_HL  = 5'd11;
    localparam logic [4:0] STEP_NX_HH  = 5'd12;
    localparam logic [4:0] STEP_NY_LL  = 5'd13;
    localparam logic [4:0] STEP_NY_LH  = 5'd14;
    localparam logic [4:0] STEP_NY_HL  = 5'd15;
    localparam logic [4:0] STEP_NY_HH  = 5'd16;
    localparam logic [4:0] STEP_DEN_LO = 5'd17;
    localparam logic [4:0] STEP_DEN_HI = 5'd18;

    localparam logic [47:0] MAG_LIMIT = 48'h8000_0000_0000;
    localparam logic [47:0] SUM_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SUM_MIN   = 48'h8000_0000_0000;

    back_state_t state_reg;
    back_state_t state_next;

    job_t         job_reg;
    logic [4:0]   step_reg;
    logic [4:0]   step_d_reg;
    logic         prod_valid_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [54:0]  d2_reg;
    logic [31:0]  t2_reg;
    logic [53:0]  w2_reg;
    logic [55:0]  gm_reg;
    logic [58:0]  nax_reg;
    logic [58:0]  nay_reg;
    logic [86:0]  rhs_reg;
    logic [114:0] numx_reg;
    logic [114:0] numy_reg;
    logic [55:0]  s_reg;
    logic [55:0]  s_comb;
    logic [83:0]  den_reg;
    logic [1:0]   dec_reg;
    logic signed [47:0] sum_x_reg;
    logic signed [47:0] sum_y_reg;

    logic         out_valid_reg;
    logic [1:0]   out_dec_reg;
    logic [47:0]  out_fx_reg;
    logic [47:0]  out_fy_reg;
    logic         out_done_reg;

    logic         accept;
    logic         out_free;
    logic         mul_issue;
    logic         sqrt_start;
    logic         div_start;
    logic         out_load;
    logic         acc_en;

    logic         sqrt_done;
    logic [27:0]  root;
    logic         divx_done;
    logic         divy_done;
    logic         divx_ovf;
    logic         divy_ovf;
    logic [47:0]  quot_x;
    logic [47:0]  quot_y;

    function automatic logic [47:0] axis_contrib(input logic neg, input logic ovf,
                                                 input logic [47:0] q);
        logic [47:0] mag;
        mag = (ovf || (q > MAG_LIMIT)) ? MAG_LIMIT : q;
        if (neg)
        begin
            return -mag;
        end
        else if (mag[47])
        begin
            return SUM_MAX;
        end
        return mag;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47])
        begin
            return s[48] ? SUM_MIN : SUM_MAX;
        end
        return s[47:0];
    endfunction

    assign s_comb   = {1'b0, d2_reg} + {8'b0, softening_sq, 16'b0};
    assign accept   = (job_reg.cls == CLS_LEAF) || ({9'b0, w2_reg, 24'b0} < rhs_reg);
    assign out_free = !out_valid_reg || pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.cls == CLS_EMPTY || job.cls == CLS_SELF)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_NY_HH)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (accept && s_comb != '0) ? ST_SQRT : ST_RESULT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (step_reg == STEP_DEN_HI)
                begin
                    state_next = ST_DENACC;
                end
            end
            ST_DENACC: state_next = ST_DIVGO;
            ST_DIVGO:  state_next = ST_DIV;
            ST_DIV:
            begin
                // both dividers run in lockstep
                if (divx_done && divy_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:    state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_take   = 1'b0;
        mul_issue  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        acc_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:   job_take   = job_valid;
            ST_MUL:    mul_issue  = 1'b1;
            ST_DECIDE: sqrt_start = accept && (s_comb != '0);
            ST_MUL2:   mul_issue  = 1'b1;
            ST_DIVGO:  div_start  = 1'b1;
            ST_ACC:    acc_en     = 1'b1;
            ST_RESULT: out_load   = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            STEP_AX:
            begin
                mul_a = {5'b0, job_reg.abs_x};
                mul_b = {5'b0, job_reg.abs_x};
            end
            STEP_AY:
            begin
                mul_a = {5'b0, job_reg.abs_y};
                mul_b = {5'b0, job_reg.abs_y};
            end
            STEP_THETA:
            begin
                mul_a = {16'b0, theta};
                mul_b = {16'b0, theta};
            end
            STEP_WIDTH:
            begin
                mul_a = {5'b0, job_reg.width};
                mul_b = {5'b0, job_reg.width};
            end
            STEP_GM:
            begin
                mul_a = {8'b0, grav_constant};
                mul_b = job_reg.pmass;
            end
            STEP_NAX:
            begin
                mul_a = job_reg.nmass;
                mul_b = {5'b0, job_reg.abs_x};
            end
            STEP_NAY:
            begin
                mul_a = job_reg.nmass;
                mul_b = {5'b0, job_reg.abs_y};
            end
            STEP_RHS_LO:
            begin
                mul_a = t2_reg;
                mul_b = d2_reg[31:0];
            end
            STEP_RHS_HI:
            begin
                mul_a = t2_reg;
                mul_b = {9'b0, d2_reg[54:32]};
            end
            STEP_NX_LL:
            begin
                mul_a = gm_reg[31:0];
                mul_b = nax_reg[31:0];
            end
            STEP_NX_LH:
            begin
                mul_a = gm_reg[31:0];
                mul_b = {5'b0, nax_reg[58:32]};
            end
            STEP_NX_HL:
            begin
                mul_a = {8'b0, gm_reg[55:32]};
                mul_b = nax_reg[31:0];
            end
            STEP_NX_HH:
            begin
                mul_a = {8'b0, gm_reg[55:32]};
                mul_b = {5'b0, nax_reg[58:32]};
            end
            STEP_NY_LL:
            begin
                mul_a = gm_reg[31:0];
                mul_b = nay_reg[31:0];
            end
            STEP_NY_LH:
            begin
                mul_a = gm_reg[31:0];
                mul_b = {5'b0, nay_reg[58:32]};
            end
            STEP_NY_HL:
            begin
                mul_a = {8'b0, gm_reg[55:32]};
                mul_b = nay_reg[31:0];
            end
            STEP_NY_HH:
            begin
                mul_a = {8'b0, gm_reg[55:32]};
                mul_b = {5'b0, nay_reg[58:32]};
            end
            STEP_DEN_LO:
            begin
                mul_a = s_reg[31:0];
                mul_b = {4'b0, root};
            end
            STEP_DEN_HI:
            begin
                mul_a = {8'b0, s_reg[55:32]};
                mul_b = {4'b0, root};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            step_d_reg     <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= mul_issue;
            step_d_reg     <= step_reg;
            if (job_take)
            begin
                step_reg <= STEP_AX;
            end
            else if (state_reg == ST_SQRT)
            begin
                step_reg <= STEP_DEN_LO;
            end
            else if (mul_issue)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // product of the previous step is folded into its target here
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (prod_valid_reg)
        begin
            case (step_d_reg)
                STEP_AX:     d2_reg   <= prod_reg[54:0];
                STEP_AY:     d2_reg   <= d2_reg + prod_reg[54:0];
                STEP_THETA:  t2_reg   <= prod_reg[31:0];
                STEP_WIDTH:  w2_reg   <= prod_reg[53:0];
                STEP_GM:     gm_reg   <= prod_reg[55:0];
                STEP_NAX:    nax_reg  <= prod_reg[58:0];
                STEP_NAY:    nay_reg  <= prod_reg[58:0];
                STEP_RHS_LO: rhs_reg  <= {23'b0, prod_reg};
                STEP_RHS_HI: rhs_reg  <= rhs_reg + {prod_reg[54:0], 32'b0};
                STEP_NX_LL:  numx_reg <= {51'b0, prod_reg};
                STEP_NX_LH,
                STEP_NX_HL:  numx_reg <= numx_reg + {19'b0, prod_reg, 32'b0};
                STEP_NX_HH:  numx_reg <= numx_reg + {prod_reg[50:0], 64'b0};
                STEP_NY_LL:  numy_reg <= {51'b0, prod_reg};
                STEP_NY_LH,
                STEP_NY_HL:  numy_reg <= numy_reg + {19'b0, prod_reg, 32'b0};
                STEP_NY_HH:  numy_reg <= numy_reg + {prod_reg[50:0], 64'b0};
                STEP_DEN_LO: den_reg  <= {20'b0, prod_reg};
                STEP_DEN_HI: den_reg  <= den_reg + {prod_reg[51:0], 32'b0};
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
            dec_reg <= (job.cls == CLS_SELF) ? DEC_SELF : DEC_EMPTY;
        end
        else if (state_reg == ST_DECIDE)
        begin
            s_reg   <= s_comb;
            dec_reg <= accept ? DEC_FORCE : DEC_OPEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (job_take && job.first)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (acc_en)
        begin
            sum_x_reg <= sat_add(sum_x_reg, axis_contrib(job_reg.sign_x, divx_ovf, quot_x));
            sum_y_reg <= sat_add(sum_y_reg, axis_contrib(job_reg.sign_y, divy_ovf, quot_y));
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dec_reg  <= dec_reg;
            out_fx_reg   <= sum_x_reg;
            out_fy_reg   <= sum_y_reg;
            out_done_reg <= job_reg.last;
        end
    end

    assign empty    = !out_valid_reg;
    assign decision = out_dec_reg;
    assign force_x  = out_fx_reg;
    assign force_y  = out_fy_reg;
    assign done_res = out_done_reg;

    gnode_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s_comb),
        .done     (sqrt_done),
        .root     (root)
    );

    gnode_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({numx_reg, 8'b0}),
        .den   (den_reg),
        .done  (divx_done),
        .ovf   (divx_ovf),
        .quot  (quot_x)
    );

    gnode_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({numy_reg, 8'b0}),
        .den   (den_reg),
        .done  (divy_done),
        .ovf   (divy_ovf),
        .quot  (quot_y)
    );

endmodule

// ----- rtl/gravity_node_interaction_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_node_interaction_top
// Barnes-Hut style particle/node interaction with saturating force sums.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         push / full               first .. last
//  result    out        pop / empty               decision, force_x/y, done_res
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  empty or self nodes go straight to the result, an opened node after the multiplier steps and the opening test
//  a force evaluation runs the multiplier steps, 28 sqrt
//  iterations and 48 divide iterations, all one item at a time
//  a two-entry queue keeps taking items while the back end works
//  reset clears the queue, sums and result register; config returns to defaults
module gravity_node_interaction_top
    import gnode_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               first,
    input  logic signed [26:0] particle_x,
    input  logic signed [26:0] particle_y,
    input  logic [31:0]        particle_mass,
    input  logic [13:0]        particle_id,
    input  logic signed [26:0] node_cm_x,
    input  logic signed [26:0] node_cm_y,
    input  logic [31:0]        node_mass,
    input  logic [26:0]        node_width,
    input  logic               node_is_leaf,
    input  logic [13:0]        node_particle,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         decision,
    output logic signed [47:0] force_x,
    output logic signed [47:0] force_y,
    output logic               done_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] theta_reg;
    logic [23:0] grav_reg;
    logic [31:0] soft_reg;
    logic        cfg_wr;
    logic        job_valid;
    logic        job_take;
    job_t        job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg <= THETA_RESET;
            grav_reg  <= GRAV_RESET;
            soft_reg  <= SOFT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_THETA: theta_reg <= pwdata[15:0];
                REG_GRAV:  grav_reg  <= pwdata[23:0];
                REG_SOFT:  soft_reg  <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_THETA: prdata = {16'b0, theta_reg};
            REG_GRAV:  prdata = {8'b0, grav_reg};
            REG_SOFT:  prdata = soft_reg;
            default:   prdata = '0;
        endcase
    end

    gnode_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .first         (first),
        .particle_x    (particle_x),
        .particle_y    (particle_y),
        .particle_mass (particle_mass),
        .particle_id   (particle_id),
        .node_cm_x     (node_cm_x),
        .node_cm_y     (node_cm_y),
        .node_mass     (node_mass),
        .node_width    (node_width),
        .node_is_leaf  (node_is_leaf),
        .node_particle (node_particle),
        .last          (last),
        .job_valid     (job_valid),
        .job_take      (job_take),
        .job           (job)
    );

    gnode_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .theta         (theta_reg),
        .grav_constant (grav_reg),
        .softening_sq  (soft_reg),
        .pop           (pop),
        .empty         (empty),
        .decision      (decision),
        .force_x       (force_x),
        .force_y       (force_y),
        .done_res      (done_res)
    );

`ifndef NO_ASSERTIONS
    a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid)
        else $error("back end took a job from an empty queue");

    a_take_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> !job_take)
        else $error("back end took two jobs in consecutive cycles");

    a_full_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> job_valid)
        else $error("queue reports full but offers no job");
`endif

endmodule
